[rtl/svgd_pkg.sv]
// svgd_pkg: widths, register codes, latencies and stage types of the
// sutherland viscosity and gas density unit. no dependencies.
package svgd_pkg;

  localparam int TEMP_W = 24;
  localparam int PRES_W = 32;
  localparam int VISC_W = 40;
  localparam int GAS_W  = 32;
  localparam int OUT_W  = 48;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 40;
  localparam int IDX_W  = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_REF_VISC  = 2'd0;
  localparam logic [IDX_W-1:0] REG_REF_TEMP  = 2'd1;
  localparam logic [IDX_W-1:0] REG_SUTH_TEMP = 2'd2;
  localparam logic [IDX_W-1:0] REG_GAS_CONST = 2'd3;

  localparam logic [VISC_W-1:0] RST_REF_VISC  = 40'd18692617;
  localparam logic [TEMP_W-1:0] RST_REF_TEMP  = 24'd69926;
  localparam logic [TEMP_W-1:0] RST_SUTH_TEMP = 24'd28262;
  localparam logic [GAS_W-1:0]  RST_GAS_CONST = 32'd18808832;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_DIV = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT = 2'd2;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // divider: one quotient bit per stage
  localparam int QUO_W   = 57;
  localparam int DEN_W   = 56;
  localparam int DIV_LAT = QUO_W;

  // square root of x * 2^32, one root bit per stage
  localparam int X_W      = 56;
  localparam int ROOT_W   = 44;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int SREM_W   = ROOT_W + 1;
  localparam int SQRT_LAT = ROOT_W;

  // multiplier: 96 x 64 from 32 x 32 partial products
  localparam int MA_W    = 96;
  localparam int MB_W    = 64;
  localparam int MP_W    = MA_W + MB_W;
  localparam int MUL_LAT = 3;

  localparam int TOTAL_LAT = DIV_LAT + SQRT_LAT + 3 * MUL_LAT;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] num;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] den;
  } div_stage_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
  } sqrt_stage_t;

  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t r;
    logic [DEN_W:0] r2;
    r2 = {s.rem, s.num[QUO_W-1]};
    r.den = s.den;
    r.num = {s.num[QUO_W-2:0], 1'b0};
    if (r2 >= {1'b0, s.den}) begin
      r.rem = DEN_W'(r2 - {1'b0, s.den});
      r.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = r2[DEN_W-1:0];
      r.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic sqrt_stage_t sqrt_step(sqrt_stage_t s);
    sqrt_stage_t r;
    logic [SREM_W+1:0] r4;
    logic [SREM_W+1:0] trial;
    r4    = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (r4 >= trial) begin
      r.rem  = SREM_W'(r4 - trial);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = r4[SREM_W-1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[rtl/svgd_if.sv]
// svgd_if: valid/ready channel interfaces for input items and results
// depends on svgd_pkg
interface svgd_in_if;
  logic                       valid;
  logic                       ready;
  logic [svgd_pkg::TEMP_W-1:0] temperature;
  logic [svgd_pkg::PRES_W-1:0] pressure;
  modport source (output valid, temperature, pressure, input ready);
  modport sink (input valid, temperature, pressure, output ready);
endinterface

interface svgd_out_if;
  logic                       valid;
  logic                       ready;
  logic [svgd_pkg::OUT_W-1:0]  viscosity;
  logic [svgd_pkg::OUT_W-1:0]  density;
  logic [svgd_pkg::STAT_W-1:0] status;
  modport source (output valid, viscosity, density, status, input ready);
  modport sink (input valid, viscosity, density, status, output ready);
endinterface

[rtl/sutherland_viscosity_and_gas_density_unit.sv]
// sutherland_viscosity_and_gas_density_unit: sutherland viscosity and
// ideal-gas density per item. an item passes 57 divider stages, 44 square root
// stages, three 3-stage multipliers and the output register; one item per cycle
// while the result is not stalled. a stalled result stalls the whole pipeline.
// synchronous active-high reset clears valid bits and loads the register
// defaults. depends on svgd_pkg, svgd_if, svgd_div, svgd_sqrt, svgd_mul
module sutherland_viscosity_and_gas_density_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [svgd_pkg::IDX_W-1:0] cfg_index,
  input  logic [svgd_pkg::CFG_W-1:0] cfg_data,
  svgd_in_if.sink                    sample,
  svgd_out_if.source                 result
);

  localparam int TOT     = svgd_pkg::TOTAL_LAT;
  localparam int X_DLY   = svgd_pkg::SQRT_LAT;
  localparam int G_DLY   = svgd_pkg::SQRT_LAT + svgd_pkg::MUL_LAT;
  localparam int DN_DLY  = TOT - svgd_pkg::MUL_LAT - svgd_pkg::DIV_LAT;
  localparam int PGE_DLY = TOT - svgd_pkg::MUL_LAT;
  localparam int HI_DLY  = svgd_pkg::MUL_LAT;

  logic [svgd_pkg::VISC_W-1:0] ref_visc;
  logic [svgd_pkg::TEMP_W-1:0] ref_temp;
  logic [svgd_pkg::TEMP_W-1:0] suth_temp;
  logic [svgd_pkg::GAS_W-1:0]  gas_const;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_visc  <= svgd_pkg::RST_REF_VISC;
      ref_temp  <= svgd_pkg::RST_REF_TEMP;
      suth_temp <= svgd_pkg::RST_SUTH_TEMP;
      gas_const <= svgd_pkg::RST_GAS_CONST;
    end else if (cfg_we) begin
      case (cfg_index)
        svgd_pkg::REG_REF_VISC:  ref_visc  <= cfg_data;
        svgd_pkg::REG_REF_TEMP:  ref_temp  <= cfg_data[svgd_pkg::TEMP_W-1:0];
        svgd_pkg::REG_SUTH_TEMP: suth_temp <= cfg_data[svgd_pkg::TEMP_W-1:0];
        svgd_pkg::REG_GAS_CONST: gas_const <= cfg_data[svgd_pkg::GAS_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic [TOT-1:0] vld;
  logic out_valid;

  assign en           = !out_valid || result.ready;
  assign sample.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[TOT-2:0], sample.valid};
      out_valid <= vld[TOT-1];
    end
  end

  // entry side
  logic [svgd_pkg::TEMP_W-1:0] temp_in;
  logic                        err_in;
  logic [svgd_pkg::TEMP_W:0]   tsum;
  logic [svgd_pkg::TEMP_W:0]   rsum;

  assign temp_in = sample.temperature;
  assign err_in  = (temp_in == '0) || (gas_const == '0) || (ref_temp == '0);
  assign tsum    = {1'b0, temp_in} + {1'b0, suth_temp};
  assign rsum    = {1'b0, ref_temp} + {1'b0, suth_temp};

  // ratio x = T * 2^32 / ref_temp
  logic [svgd_pkg::QUO_W-1:0] x_q;
  svgd_div u_div_x (
    .clk  (clk),
    .en   (en),
    .rem0 ('0),
    .num  ({1'b0, temp_in, 32'd0}),
    .den  ({32'd0, ref_temp}),
    .quo  (x_q)
  );

  // g = (ref_temp + suth_temp) * 2^32 / (T + suth_temp)
  logic [svgd_pkg::QUO_W-1:0] g_q;
  svgd_div u_div_g (
    .clk  (clk),
    .en   (en),
    .rem0 ('0),
    .num  ({rsum, 32'd0}),
    .den  ({31'd0, tsum}),
    .quo  (g_q)
  );

  logic [svgd_pkg::ROOT_W-1:0] s_q;
  svgd_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (x_q[svgd_pkg::X_W-1:0]),
    .root (s_q)
  );

  logic [svgd_pkg::X_W-1:0]   x_dl [X_DLY];
  logic [svgd_pkg::QUO_W-1:0] g_dl [G_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      x_dl[0] <= x_q[svgd_pkg::X_W-1:0];
      for (int i = 1; i < X_DLY; i++) x_dl[i] <= x_dl[i-1];
      g_dl[0] <= g_q;
      for (int i = 1; i < G_DLY; i++) g_dl[i] <= g_dl[i-1];
    end
  end

  // r = x * s / 2^32
  logic [svgd_pkg::MP_W-1:0] prod_r;
  svgd_mul u_mul_r (
    .clk  (clk),
    .en   (en),
    .a    ({40'd0, x_dl[X_DLY-1]}),
    .b    ({20'd0, s_q}),
    .prod (prod_r)
  );

  // t = r * g / 2^32
  logic [svgd_pkg::MP_W-1:0] prod_t;
  svgd_mul u_mul_t (
    .clk  (clk),
    .en   (en),
    .a    ({28'd0, prod_r[99:32]}),
    .b    ({7'd0, g_dl[G_DLY-1]}),
    .prod (prod_t)
  );

  // t above 88 bits always overflows the viscosity unless ref_visc is zero
  logic t_hi;
  logic hi_dl [HI_DLY];
  assign t_hi = |prod_t[159:120];

  always_ff @(posedge clk) begin
    if (en) begin
      hi_dl[0] <= t_hi;
      for (int i = 1; i < HI_DLY; i++) hi_dl[i] <= hi_dl[i-1];
    end
  end

  logic [svgd_pkg::MP_W-1:0] prod_v;
  svgd_mul u_mul_v (
    .clk  (clk),
    .en   (en),
    .a    ({8'd0, prod_t[119:32]}),
    .b    ({24'd0, ref_visc}),
    .prod (prod_v)
  );

  // density path: d = gas_const * T, then p * 2^57 / d
  logic [svgd_pkg::MP_W-1:0] prod_d;
  svgd_mul u_mul_d (
    .clk  (clk),
    .en   (en),
    .a    ({72'd0, temp_in}),
    .b    ({32'd0, gas_const}),
    .prod (prod_d)
  );

  logic [svgd_pkg::PRES_W-1:0] p_dl [svgd_pkg::MUL_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      p_dl[0] <= sample.pressure;
      for (int i = 1; i < svgd_pkg::MUL_LAT; i++) p_dl[i] <= p_dl[i-1];
    end
  end

  logic [svgd_pkg::DEN_W-1:0]  d_val;
  logic [svgd_pkg::PRES_W-1:0] p_d;
  logic                        pge;
  assign d_val = prod_d[svgd_pkg::DEN_W-1:0];
  assign p_d   = p_dl[svgd_pkg::MUL_LAT-1];
  assign pge   = {24'd0, p_d} >= d_val;

  logic [svgd_pkg::QUO_W-1:0] dn_q;
  svgd_div u_div_d (
    .clk  (clk),
    .en   (en),
    .rem0 ({24'd0, p_d}),
    .num  ('0),
    .den  (d_val),
    .quo  (dn_q)
  );

  logic [svgd_pkg::OUT_W-1:0] dn_dl  [DN_DLY];
  logic                       pge_dl [PGE_DLY];
  logic                       err_dl [TOT];

  always_ff @(posedge clk) begin
    if (en) begin
      dn_dl[0] <= dn_q[svgd_pkg::QUO_W-1 -: svgd_pkg::OUT_W];
      for (int i = 1; i < DN_DLY; i++) dn_dl[i] <= dn_dl[i-1];
      pge_dl[0] <= pge;
      for (int i = 1; i < PGE_DLY; i++) pge_dl[i] <= pge_dl[i-1];
      err_dl[0] <= err_in;
      for (int i = 1; i < TOT; i++) err_dl[i] <= err_dl[i-1];
    end
  end

  // final selection
  logic                         visc_sat;
  logic                         dens_sat;
  logic [svgd_pkg::OUT_W-1:0]   visc_next;
  logic [svgd_pkg::OUT_W-1:0]   dens_next;
  logic [svgd_pkg::STAT_W-1:0]  status_next;

  always_comb begin
    visc_sat = (ref_visc != '0) && (hi_dl[HI_DLY-1] || (|prod_v[159:80]));
    dens_sat = pge_dl[PGE_DLY-1];
    if (err_dl[TOT-1]) begin
      visc_next   = '0;
      dens_next   = '0;
      status_next = svgd_pkg::ST_DIV;
    end else begin
      if (ref_visc == '0) visc_next = '0;
      else if (visc_sat) visc_next = svgd_pkg::OUT_MAX;
      else visc_next = prod_v[79:32];
      dens_next   = dens_sat ? svgd_pkg::OUT_MAX : dn_dl[DN_DLY-1];
      status_next = (visc_sat || dens_sat) ? svgd_pkg::ST_SAT : svgd_pkg::ST_OK;
    end
  end

  logic [svgd_pkg::OUT_W-1:0]  visc_q;
  logic [svgd_pkg::OUT_W-1:0]  dens_q;
  logic [svgd_pkg::STAT_W-1:0] status_q;

  always_ff @(posedge clk) begin
    if (en) begin
      visc_q   <= visc_next;
      dens_q   <= dens_next;
      status_q <= status_next;
    end
  end

  assign result.valid     = out_valid;
  assign result.viscosity = visc_q;
  assign result.density   = dens_q;
  assign result.status    = status_q;

endmodule

[rtl/svgd_div.sv]
// svgd_div: pipelined restoring divider, one quotient bit per stage
// depends on svgd_pkg
module svgd_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [svgd_pkg::DEN_W-1:0] rem0,
  input  logic [svgd_pkg::QUO_W-1:0] num,
  input  logic [svgd_pkg::DEN_W-1:0] den,
  output logic [svgd_pkg::QUO_W-1:0] quo
);

  svgd_pkg::div_stage_t st [svgd_pkg::DIV_LAT];
  svgd_pkg::div_stage_t first;

  always_comb begin
    first.rem = rem0;
    first.num = num;
    first.quo = '0;
    first.den = den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= svgd_pkg::div_step(first);
      for (int i = 1; i < svgd_pkg::DIV_LAT; i++) begin
        st[i] <= svgd_pkg::div_step(st[i-1]);
      end
    end
  end

  assign quo = st[svgd_pkg::DIV_LAT-1].quo;

endmodule

[rtl/svgd_sqrt.sv]
// svgd_sqrt: pipelined integer square root of x * 2^32, one bit per stage
// depends on svgd_pkg
module svgd_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [svgd_pkg::X_W-1:0]    x,
  output logic [svgd_pkg::ROOT_W-1:0] root
);

  svgd_pkg::sqrt_stage_t st [svgd_pkg::SQRT_LAT];
  svgd_pkg::sqrt_stage_t first;

  always_comb begin
    first.rem  = '0;
    first.rad  = {x, 32'd0};
    first.root = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= svgd_pkg::sqrt_step(first);
      for (int i = 1; i < svgd_pkg::SQRT_LAT; i++) begin
        st[i] <= svgd_pkg::sqrt_step(st[i-1]);
      end
    end
  end

  assign root = st[svgd_pkg::SQRT_LAT-1].root;

endmodule

[rtl/svgd_mul.sv]
// svgd_mul: three-stage 96 x 64 multiplier built from 32 x 32 products
// depends on svgd_pkg
module svgd_mul (
  input  logic                      clk,
  input  logic                      en,
  input  logic [svgd_pkg::MA_W-1:0] a,
  input  logic [svgd_pkg::MB_W-1:0] b,
  output logic [svgd_pkg::MP_W-1:0] prod
);

  logic [63:0]  pp [3][2];
  logic [127:0] row [2];
  logic [svgd_pkg::MP_W-1:0] prod_q;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 2; j++) begin
          pp[i][j] <= a[32*i +: 32] * b[32*j +: 32];
        end
      end
      // one row per 32-bit digit of b
      for (int j = 0; j < 2; j++) begin
        row[j] <= {64'd0, pp[0][j]} + {32'd0, pp[1][j], 32'd0} + {pp[2][j], 64'd0};
      end
      prod_q <= {32'd0, row[0]} + {row[1], 32'd0};
    end
  end

  assign prod = prod_q;

endmodule
